>>> rtl/core/assert_macros.svh
// Assertion macros used by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define MPQS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("queue check failed: always");

// Check that an antecedent is followed in the next cycle by a consequent.
`define MPQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed: next cycle");

`endif

>>> rtl/core/mpqs_pkg.sv
// Package for the sorted priority queue: sizes, codes and shared types.
`default_nettype none
package mpqs_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_POP    = 1'b1
  } mpqs_func_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } mpqs_status_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } mpqs_entry_t;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } mpqs_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/mpqs_cell.sv
// One slot of the sorted chain: holds an entry, compares, shifts.
`default_nettype none
module mpqs_cell (
  input  wire                  clk,
  input  mpqs_pkg::mpqs_ctl_t  ctl,
  input  wire                  occ,
  input  wire                  left_gt,
  input  mpqs_pkg::mpqs_entry_t new_ent,
  input  mpqs_pkg::mpqs_entry_t left_ent,
  input  mpqs_pkg::mpqs_entry_t right_ent,
  output mpqs_pkg::mpqs_entry_t cur_ent,
  output logic                 gt
);
  import mpqs_pkg::*;

  mpqs_entry_t ent_r;
  mpqs_entry_t ent_nxt;

  // Stored entry outranks the new key: it stays ahead of it.
  assign gt      = occ && (ent_r.key > new_ent.key);
  assign cur_ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.ins) begin
      if (gt) begin
        ent_nxt = ent_r;
      end else if (left_gt) begin
        ent_nxt = new_ent;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end else begin
      // Idle cycle: hold the entry.
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/max_priority_queue_sorted_top.sv
// Top level of the sorted-list max-priority queue built as a chain of cells.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_func, in_key, in_payload
//   out_    | output    | out_valid / out_ready | out_status, out_key, out_payload
//
// On an insert every cell compares its key against the new key and loads
// itself, its left neighbor or the new entry in the same edge; on a pop it loads its right neighbor.
// One item per cycle is sustained while out_ready stays high.
// The result register decouples the sides: a new item enters whenever the
// result register is empty or is being emptied in the same cycle.
// Reset clears only the fill count and the result valid; slot contents
// are undefined until written and never reach the output from above the fill count.
`default_nettype none
`include "assert_macros.svh"
module max_priority_queue_sorted_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            in_func,
  input  wire  [31:0]                    in_key,
  input  wire  [mpqs_pkg::PAYLOAD_W-1:0] in_payload,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_key,
  output logic [mpqs_pkg::PAYLOAD_W-1:0] out_payload
);
  import mpqs_pkg::*;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  mpqs_status_t         status_r;
  mpqs_status_t         status_nxt;
  logic [31:0]          key_r;
  logic [31:0]          key_nxt;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [PAYLOAD_W-1:0] payload_nxt;

  logic        accept;
  logic        full;
  logic        empty;
  mpqs_func_t  func;
  mpqs_ctl_t   ctl;
  mpqs_entry_t new_ent;
  mpqs_entry_t ents [DEPTH];
  logic        gts  [DEPTH];

  assign func    = mpqs_func_t'(in_func);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  // Take a new item whenever the result slot is free or draining.
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign new_ent.key     = in_key[KEY_W-1:0];
  assign new_ent.payload = in_payload;

  // Drop inserts into a full queue and pops of an empty one: no shift.
  assign ctl.ins = accept && (func == FUNC_INSERT) && !full;
  assign ctl.pop = accept && (func == FUNC_POP) && !empty;

  // The chain: slot 0 is the head, data moves right on insert, left on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        occ;
    logic        left_gt;
    mpqs_entry_t left_ent;
    mpqs_entry_t right_ent;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_gt  = 1'b1;
      assign left_ent = new_ent;
    end else begin : g_mid
      assign left_gt  = gts[i-1];
      assign left_ent = ents[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ents[i+1];
    end

    mpqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_gt   (left_gt),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .cur_ent   (ents[i]),
      .gt        (gts[i])
    );
  end

  // Fill count tracks the number of live slots.
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Build the result for the accepted item; hold it until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    key_nxt       = key_r;
    payload_nxt   = payload_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      key_nxt       = '0;
      payload_nxt   = '0;
      unique case (func)
        FUNC_INSERT: begin
          status_nxt = full ? ST_DROPPED : ST_INSERTED;
        end
        FUNC_POP: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt  = ST_POPPED;
            key_nxt     = 32'(ents[0].key);
            payload_nxt = ents[0].payload;
          end
        end
        default: begin
          status_nxt = ST_INSERTED;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_key     = key_r;
  assign out_payload = payload_r;

  `MPQS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `MPQS_ASSERT_NEXT(a_ins_grows, ctl.ins, count_r == $past(count_r) + CNT_W'(1))
  `MPQS_ASSERT_NEXT(a_pop_shrinks, ctl.pop, count_r == $past(count_r) - CNT_W'(1))
  `MPQS_ASSERT_NEXT(a_empty_pop, accept && func == FUNC_POP && empty, out_status == ST_EMPTY && out_valid)

endmodule
`default_nettype wire
